[rtl/apid_pkg.sv]
// Package for the attitude PID controller.
// Holds the control state type, step codes, limits and small arithmetic helpers.
// Used by apid_smul and attitude_pid_controller; depends on nothing.
package apid_pkg;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_START,
        CS_WAIT,
        CS_FLUSH
    } ctrl_state_t;

    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 10;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam logic [1:0] MODE_RATE    = 2'd0;
    localparam logic [1:0] MODE_ANGLE   = 2'd1;
    localparam logic [1:0] MODE_HORIZON = 2'd2;

    localparam logic [2:0] REG_ROLL_GAINS  = 3'd0;
    localparam logic [2:0] REG_PITCH_GAINS = 3'd1;
    localparam logic [2:0] REG_YAW_GAINS   = 3'd2;
    localparam logic [2:0] REG_LEVEL_GAINS = 3'd3;
    localparam logic [2:0] REG_YAW_RATE    = 3'd4;
    localparam logic [2:0] REG_TRIM_ROLL   = 3'd5;
    localparam logic [2:0] REG_TRIM_PITCH  = 3'd6;

    localparam logic [3:0] STEP_DYNP   = 4'd0;
    localparam logic [3:0] STEP_DYND   = 4'd1;
    localparam logic [3:0] STEP_ITERM  = 4'd2;
    localparam logic [3:0] STEP_PTERM  = 4'd3;
    localparam logic [3:0] STEP_PACC   = 4'd4;
    localparam logic [3:0] STEP_IACC   = 4'd5;
    localparam logic [3:0] STEP_IBLEND = 4'd6;
    localparam logic [3:0] STEP_PBLEND = 4'd7;
    localparam logic [3:0] STEP_DYNPG  = 4'd8;
    localparam logic [3:0] STEP_DTERM  = 4'd9;

    localparam logic [3:0] YSTEP_CMD = 4'd0;
    localparam logic [3:0] YSTEP_INT = 4'd1;
    localparam logic [3:0] YSTEP_OUT = 4'd2;

    localparam logic signed [31:0] RATE_I_LIM    = 32'sd16000;
    localparam logic signed [31:0] LEVEL_I_LIM   = 32'sd10000;
    localparam logic signed [31:0] FAST_GYRO     = 32'sd640;
    localparam logic signed [31:0] LEVEL_CMD_LIM = 32'sd500;
    localparam logic signed [31:0] YAW_P_BASE    = 32'sd300;
    localparam logic signed [31:0] YAW_I_LIM     = 32'sd250;
    localparam logic signed [31:0] YAW_BIG_CMD   = 32'sd50;
    localparam logic signed [31:0] YAW_I_MAX     = 32'sd268435454;
    localparam logic [9:0]         YAW_RATE_OFS  = 10'd30;
    localparam logic [7:0]         ATTEN_FULL    = 8'd128;

    function automatic logic signed [31:0] clamp_s32(
        input logic signed [31:0] v,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        logic signed [31:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] abs_s32(input logic signed [31:0] v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

[rtl/apid_smul.sv]
// Bit-serial shift-add multiplier: signed multiplicand by unsigned multiplier.
// One multiplier bit per cycle; busy stays high until the product is final.
// Depends on apid_pkg for the operand widths.
module apid_smul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [apid_pkg::MUL_A_W-1:0] a,
    input  logic        [apid_pkg::MUL_B_W-1:0] b,
    output logic                                busy,
    output logic signed [apid_pkg::MUL_A_W-1:0] product
);
    import apid_pkg::*;

    logic signed [MUL_A_W-1:0] a_reg, a_next;
    logic        [MUL_B_W-1:0] b_reg, b_next;
    logic signed [MUL_A_W-1:0] acc_reg, acc_next;
    logic      [MUL_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
            cnt_next = MUL_CNT_W'(MUL_B_W);
        end
        else if (cnt_reg != '0)
        begin
            acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

endmodule

[rtl/attitude_pid_controller.sv]
// Top level of the attitude PID controller: stream ports, register port, step sequencer.
// Depends on apid_pkg and on the bit-serial multiplier apid_smul.
//
// Each item runs 23 multiplications one after another through the single bit-serial
// multiplier; each one loads its operands, shifts through the ten multiplier bits and stores the
// product. Accepting the item and moving the result to the output register are steps of their
// own. The next item is taken while a finished result still waits on the output side.
module attitude_pid_controller (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // gyro_roll, gyro_pitch, gyro_yaw, cmd_roll, cmd_pitch, cmd_yaw,
    // angle_roll, angle_pitch, atten_roll, atten_pitch, throttle_low
    input  logic [119:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pid_roll, pid_pitch, pid_yaw
    output logic [47:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import apid_pkg::*;

    ctrl_state_t state_reg, state_next;

    logic [23:0]        roll_gains_reg, pitch_gains_reg, yaw_gains_reg, level_gains_reg;
    logic [7:0]         yaw_rate_reg;
    logic signed [10:0] trim_roll_reg, trim_pitch_reg;

    logic signed [13:0] gyro_reg [2];
    logic signed [13:0] gyro_reg_next [2];
    logic signed [9:0]  cmd_reg [2];
    logic signed [9:0]  cmd_reg_next [2];
    logic signed [11:0] ang_reg [2];
    logic signed [11:0] ang_reg_next [2];
    logic [7:0]         atten_reg [2];
    logic [7:0]         atten_reg_next [2];
    logic signed [13:0] gyro_yaw_reg, gyro_yaw_next;
    logic signed [9:0]  cmd_yaw_reg, cmd_yaw_next;

    logic signed [15:0] rate_int_reg [2];
    logic signed [15:0] rate_int_next [2];
    logic signed [14:0] level_int_reg [2];
    logic signed [14:0] level_int_next [2];
    logic signed [28:0] yaw_int_reg, yaw_int_next;
    logic signed [15:0] prior_reg [2];
    logic signed [15:0] prior_next [2];
    logic signed [15:0] d1_reg [2];
    logic signed [15:0] d1_next [2];
    logic signed [15:0] d2_reg [2];
    logic signed [15:0] d2_next [2];
    logic               angle_act_reg, angle_act_next;
    logic               horizon_act_reg, horizon_act_next;

    logic               ax_reg, ax_next;
    logic               yaw_reg, yaw_next;
    logic [3:0]         step_reg, step_next;
    logic [9:0]         prop_reg, prop_next;
    logic [7:0]         dynp_reg, dynp_next;
    logic [7:0]         dynd_reg, dynd_next;
    logic signed [15:0] iterm_reg, iterm_next;
    logic signed [15:0] pterm_reg, pterm_next;
    logic signed [15:0] pacc_reg, pacc_next;
    logic signed [15:0] iacc_reg, iacc_next;
    logic signed [13:0] ea_reg, ea_next;
    logic signed [15:0] dsum_reg, dsum_next;
    logic signed [16:0] yerr_reg, yerr_next;
    logic               ybig_reg, ybig_next;
    logic signed [15:0] res_reg [2];
    logic signed [15:0] res_reg_next [2];
    logic signed [15:0] res_yaw_reg, res_yaw_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic               accept, mul_start, post_en, out_load, last_step, level;
    logic               mul_busy;
    logic signed [31:0] mul_a, prod;
    logic [9:0]         mul_b;

    logic               cfg_wr;
    logic [23:0]        gains_a;
    logic [7:0]         p8, i8, d8, lp, li8, ld, yp8, yi8, yd8, atten_a, at_a;
    logic signed [31:0] gyro_a, cmd_a, rc_a, err_a, ri_new, ea_a, li_new, trim_a;
    logic signed [31:0] delta_a, dsum_a, cr_abs, cp_abs, plim, yrc, ylim;
    logic signed [31:0] ypt, yit;
    logic signed [15:0] ypw, dterm16;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[4:2])
            REG_ROLL_GAINS:  prdata = {8'd0, roll_gains_reg};
            REG_PITCH_GAINS: prdata = {8'd0, pitch_gains_reg};
            REG_YAW_GAINS:   prdata = {8'd0, yaw_gains_reg};
            REG_LEVEL_GAINS: prdata = {8'd0, level_gains_reg};
            REG_YAW_RATE:    prdata = {24'd0, yaw_rate_reg};
            REG_TRIM_ROLL:   prdata = 32'(trim_roll_reg);
            REG_TRIM_PITCH:  prdata = 32'(trim_pitch_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_gains_reg  <= '0;
            pitch_gains_reg <= '0;
            yaw_gains_reg   <= '0;
            level_gains_reg <= '0;
            yaw_rate_reg    <= '0;
            trim_roll_reg   <= '0;
            trim_pitch_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ROLL_GAINS:  roll_gains_reg  <= pwdata[23:0];
                REG_PITCH_GAINS: pitch_gains_reg <= pwdata[23:0];
                REG_YAW_GAINS:   yaw_gains_reg   <= pwdata[23:0];
                REG_LEVEL_GAINS: level_gains_reg <= pwdata[23:0];
                REG_YAW_RATE:    yaw_rate_reg    <= pwdata[7:0];
                REG_TRIM_ROLL:   trim_roll_reg   <= pwdata[10:0];
                REG_TRIM_PITCH:  trim_pitch_reg  <= pwdata[10:0];
                default:         ;
            endcase
        end
    end

    // Sequencer.
    assign last_step = yaw_reg && (step_reg == YSTEP_OUT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = CS_START;
                end
            end
            CS_START: state_next = CS_WAIT;
            CS_WAIT:
            begin
                if (!mul_busy)
                begin
                    state_next = last_step ? CS_FLUSH : CS_START;
                end
            end
            CS_FLUSH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        post_en   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            CS_IDLE:  s_tready  = 1'b1;
            CS_START: mul_start = 1'b1;
            CS_WAIT:  post_en   = !mul_busy;
            CS_FLUSH: out_load  = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign level  = angle_act_reg || horizon_act_reg;

    // Operands of the current axis.
    assign gains_a = ax_reg ? pitch_gains_reg : roll_gains_reg;
    assign p8      = gains_a[7:0];
    assign i8      = gains_a[15:8];
    assign d8      = gains_a[23:16];
    assign lp      = level_gains_reg[7:0];
    assign li8     = level_gains_reg[15:8];
    assign ld      = level_gains_reg[23:16];
    assign yp8     = yaw_gains_reg[7:0];
    assign yi8     = yaw_gains_reg[15:8];
    assign yd8     = yaw_gains_reg[23:16];
    assign atten_a = atten_reg[ax_reg];
    assign at_a    = (atten_a > ATTEN_FULL) ? ATTEN_FULL : atten_a;
    assign trim_a  = ax_reg ? 32'(trim_pitch_reg) : 32'(trim_roll_reg);

    assign gyro_a  = 32'(gyro_reg[ax_reg]);
    assign cmd_a   = 32'(cmd_reg[ax_reg]);
    assign rc_a    = cmd_a + cmd_a;
    assign err_a   = rc_a - gyro_a;
    assign ri_new  = (abs_s32(gyro_a) > FAST_GYRO) ? 32'sd0
                   : clamp_s32(32'(rate_int_reg[ax_reg]) + err_a, -RATE_I_LIM, RATE_I_LIM);
    assign ea_a    = clamp_s32(rc_a, -LEVEL_CMD_LIM, LEVEL_CMD_LIM)
                   - 32'(ang_reg[ax_reg]) + trim_a;
    assign li_new  = clamp_s32(32'(level_int_reg[ax_reg]) + ea_a, -LEVEL_I_LIM, LEVEL_I_LIM);
    assign delta_a = gyro_a - 32'(prior_reg[ax_reg]);
    assign dsum_a  = 32'(d1_reg[ax_reg]) + 32'(d2_reg[ax_reg]) + delta_a;
    assign plim    = 32'({ld, 2'b00}) + 32'(ld);

    assign yrc     = prod >>> 5;
    assign ylim    = YAW_P_BASE - 32'(yd8);
    assign ypw     = 16'(prod >>> 6);
    assign ypt     = clamp_s32(32'(ypw), -ylim, ylim);
    assign yit     = clamp_s32(32'(yaw_int_reg) >>> 13, -YAW_I_LIM, YAW_I_LIM);
    assign dterm16 = 16'(prod >>> 5);

    assign cr_abs  = abs_s32(32'($signed(s_tdata[51:42])));
    assign cp_abs  = abs_s32(32'($signed(s_tdata[61:52])));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (yaw_reg)
        begin
            case (step_reg)
                YSTEP_CMD:
                begin
                    mul_a = 32'(cmd_yaw_reg);
                    mul_b = {1'b0, yaw_rate_reg, 1'b0} + YAW_RATE_OFS;
                end
                YSTEP_INT:
                begin
                    mul_a = 32'(yerr_reg);
                    mul_b = {2'b00, yi8};
                end
                YSTEP_OUT:
                begin
                    mul_a = 32'(yerr_reg);
                    mul_b = {2'b00, yp8};
                end
                default: ;
            endcase
        end
        else
        begin
            case (step_reg)
                STEP_DYNP:
                begin
                    mul_a = {24'd0, p8};
                    mul_b = {2'b00, at_a};
                end
                STEP_DYND:
                begin
                    mul_a = {24'd0, d8};
                    mul_b = {2'b00, at_a};
                end
                STEP_ITERM:
                begin
                    mul_a = 32'(rate_int_reg[ax_reg]) >>> 7;
                    mul_b = {2'b00, i8};
                end
                STEP_PTERM:
                begin
                    mul_a = rc_a;
                    mul_b = {2'b00, p8};
                end
                STEP_PACC:
                begin
                    mul_a = 32'(ea_reg);
                    mul_b = {2'b00, lp};
                end
                STEP_IACC:
                begin
                    mul_a = 32'(level_int_reg[ax_reg]);
                    mul_b = {2'b00, li8};
                end
                STEP_IBLEND:
                begin
                    mul_a = 32'(iterm_reg) - 32'(iacc_reg);
                    mul_b = prop_reg;
                end
                STEP_PBLEND:
                begin
                    mul_a = 32'(pterm_reg) - 32'(pacc_reg);
                    mul_b = prop_reg;
                end
                STEP_DYNPG:
                begin
                    mul_a = gyro_a;
                    mul_b = {2'b00, dynp_reg};
                end
                STEP_DTERM:
                begin
                    mul_a = 32'(dsum_reg);
                    mul_b = {2'b00, dynd_reg};
                end
                default: ;
            endcase
        end
    end

    apid_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (prod)
    );

    // Datapath updates.
    always_comb
    begin
        gyro_reg_next    = gyro_reg;
        cmd_reg_next     = cmd_reg;
        ang_reg_next     = ang_reg;
        atten_reg_next   = atten_reg;
        gyro_yaw_next    = gyro_yaw_reg;
        cmd_yaw_next     = cmd_yaw_reg;
        rate_int_next    = rate_int_reg;
        level_int_next   = level_int_reg;
        yaw_int_next     = yaw_int_reg;
        prior_next       = prior_reg;
        d1_next          = d1_reg;
        d2_next          = d2_reg;
        angle_act_next   = angle_act_reg;
        horizon_act_next = horizon_act_reg;
        ax_next          = ax_reg;
        yaw_next         = yaw_reg;
        step_next        = step_reg;
        prop_next        = prop_reg;
        dynp_next        = dynp_reg;
        dynd_next        = dynd_reg;
        iterm_next       = iterm_reg;
        pterm_next       = pterm_reg;
        pacc_next        = pacc_reg;
        iacc_next        = iacc_reg;
        ea_next          = ea_reg;
        dsum_next        = dsum_reg;
        yerr_next        = yerr_reg;
        ybig_next        = ybig_reg;
        res_reg_next     = res_reg;
        res_yaw_next     = res_yaw_reg;

        if (accept)
        begin
            gyro_reg_next[0]  = s_tdata[13:0];
            gyro_reg_next[1]  = s_tdata[27:14];
            gyro_yaw_next     = s_tdata[41:28];
            cmd_reg_next[0]   = s_tdata[51:42];
            cmd_reg_next[1]   = s_tdata[61:52];
            cmd_yaw_next      = s_tdata[71:62];
            ang_reg_next[0]   = s_tdata[83:72];
            ang_reg_next[1]   = s_tdata[95:84];
            atten_reg_next[0] = s_tdata[103:96];
            atten_reg_next[1] = s_tdata[111:104];

            // Entering a level mode clears the level integrators, leaving one clears
            // the rate integrators, and throttle low clears everything.
            if (s_tdata[112]
                || (s_tuser != MODE_ANGLE && angle_act_reg)
                || (s_tuser != MODE_HORIZON && horizon_act_reg))
            begin
                rate_int_next[0] = '0;
                rate_int_next[1] = '0;
            end
            if (s_tdata[112]
                || (s_tuser == MODE_ANGLE && !angle_act_reg)
                || (s_tuser == MODE_HORIZON && !horizon_act_reg))
            begin
                level_int_next[0] = '0;
                level_int_next[1] = '0;
            end
            if (s_tdata[112])
            begin
                yaw_int_next = '0;
            end
            angle_act_next   = (s_tuser == MODE_ANGLE);
            horizon_act_next = (s_tuser == MODE_HORIZON);
            if (s_tuser == MODE_HORIZON)
            begin
                prop_next = (cp_abs > cr_abs) ? 10'(cp_abs) : 10'(cr_abs);
            end
            else
            begin
                prop_next = '0;
            end
            ax_next   = 1'b0;
            yaw_next  = 1'b0;
            step_next = STEP_DYNP;
        end

        if (post_en)
        begin
            step_next = step_reg + 1'b1;
            if (yaw_reg)
            begin
                case (step_reg)
                    YSTEP_CMD:
                    begin
                        yerr_next = 17'(yrc - 32'(gyro_yaw_reg));
                        ybig_next = abs_s32(yrc) > YAW_BIG_CMD;
                    end
                    YSTEP_INT:
                    begin
                        if (ybig_reg)
                        begin
                            yaw_int_next = '0;
                        end
                        else
                        begin
                            yaw_int_next = 29'(clamp_s32(32'(yaw_int_reg) + prod,
                                                         -YAW_I_MAX, YAW_I_MAX));
                        end
                    end
                    YSTEP_OUT:
                    begin
                        res_yaw_next = 16'(ypt + yit);
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (step_reg)
                    STEP_DYNP:
                    begin
                        dynp_next              = prod[14:7];
                        rate_int_next[ax_reg]  = 16'(ri_new);
                        if (level)
                        begin
                            level_int_next[ax_reg] = 15'(li_new);
                        end
                        ea_next                = 14'(ea_a);
                        prior_next[ax_reg]     = 16'(gyro_a);
                        d2_next[ax_reg]        = d1_reg[ax_reg];
                        d1_next[ax_reg]        = 16'(delta_a);
                        dsum_next              = 16'(dsum_a);
                    end
                    STEP_DYND:  dynd_next  = prod[14:7];
                    STEP_ITERM: iterm_next = 16'(prod >>> 6);
                    STEP_PTERM: pterm_next = 16'(prod >>> 6);
                    STEP_PACC:  pacc_next  = 16'(clamp_s32(prod >>> 7, -plim, plim));
                    STEP_IACC:  iacc_next  = 16'(prod >>> 12);
                    STEP_IBLEND:
                    begin
                        if (level)
                        begin
                            iterm_next = 16'(32'(iacc_reg) + (prod >>> 9));
                        end
                    end
                    STEP_PBLEND:
                    begin
                        if (level)
                        begin
                            pterm_next = 16'(32'(pacc_reg) + (prod >>> 9));
                        end
                    end
                    STEP_DYNPG: pterm_next = 16'(32'(pterm_reg) - (prod >>> 6));
                    STEP_DTERM:
                    begin
                        res_reg_next[ax_reg] = pterm_reg + iterm_reg - dterm16;
                        step_next            = STEP_DYNP;
                        if (ax_reg)
                        begin
                            yaw_next = 1'b1;
                        end
                        else
                        begin
                            ax_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Output register.
    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tdata_next  = {res_yaw_reg, res_reg[1], res_reg[0]};
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= CS_IDLE;
            m_tvalid_reg    <= 1'b0;
            rate_int_reg    <= '{default: '0};
            level_int_reg   <= '{default: '0};
            yaw_int_reg     <= '0;
            prior_reg       <= '{default: '0};
            d1_reg          <= '{default: '0};
            d2_reg          <= '{default: '0};
            angle_act_reg   <= 1'b0;
            horizon_act_reg <= 1'b0;
            ax_reg          <= 1'b0;
            yaw_reg         <= 1'b0;
            step_reg        <= STEP_DYNP;
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            rate_int_reg    <= rate_int_next;
            level_int_reg   <= level_int_next;
            yaw_int_reg     <= yaw_int_next;
            prior_reg       <= prior_next;
            d1_reg          <= d1_next;
            d2_reg          <= d2_next;
            angle_act_reg   <= angle_act_next;
            horizon_act_reg <= horizon_act_next;
            ax_reg          <= ax_next;
            yaw_reg         <= yaw_next;
            step_reg        <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gyro_reg     <= gyro_reg_next;
        cmd_reg      <= cmd_reg_next;
        ang_reg      <= ang_reg_next;
        atten_reg    <= atten_reg_next;
        gyro_yaw_reg <= gyro_yaw_next;
        cmd_yaw_reg  <= cmd_yaw_next;
        prop_reg     <= prop_next;
        dynp_reg     <= dynp_next;
        dynd_reg     <= dynd_next;
        iterm_reg    <= iterm_next;
        pterm_reg    <= pterm_next;
        pacc_reg     <= pacc_next;
        iacc_reg     <= iacc_next;
        ea_reg       <= ea_next;
        dsum_reg     <= dsum_next;
        yerr_reg     <= yerr_next;
        ybig_reg     <= ybig_next;
        res_reg      <= res_reg_next;
        res_yaw_reg  <= res_yaw_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule
